>>> rtl/drac_pkg.sv
// Package for the damage rectangle accumulator.
// Holds payload structs, state codes, rectangle types and geometry functions.
// No dependencies.
package drac_pkg;

  localparam int unsigned FRAME_LIMIT  = 8192;
  localparam int unsigned PERCENT_BASE = 100;
  localparam int unsigned CFG_AW       = 3;
  localparam int unsigned CFG_DW       = 14;

  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MERGE_PAD    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SIGNAL_MAX   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_AREA_PERCENT = 3'd4;

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_CAPTURE = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_w;
    logic signed [15:0] rect_h;
  } in_req_t;

  typedef struct packed {
    logic [12:0] out_x;
    logic [12:0] out_y;
    logic [13:0] out_w;
    logic [13:0] out_h;
    logic        partial_damage;
    logic        last_rect;
    logic [6:0]  rect_total;
  } out_req_t;

  // Stored rectangle, 54 bits.
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic [13:0] w;
    logic [13:0] h;
  } box_t;

  // Working rectangle with room for signed sums.
  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] w;
    logic signed [17:0] h;
  } wbox_t;

  typedef struct packed {
    logic  ok;
    wbox_t b;
  } clamp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD_F0, ST_SCAN_RD, ST_SCAN_CHK, ST_COLLAPSE,
    ST_ABS_RD, ST_ABS_CHK, ST_ABS_MV,
    ST_AR_RD, ST_AR_MUL, ST_AR_ACC, ST_AR_THR, ST_AR_FLG,
    ST_EM_RD, ST_EM_LD, ST_EM_WT
  } state_t;

  function automatic wbox_t widen(input box_t b);
    wbox_t o;
    o.x = signed'({5'd0, b.x});
    o.y = signed'({5'd0, b.y});
    o.w = signed'({4'd0, b.w});
    o.h = signed'({4'd0, b.h});
    return o;
  endfunction

  function automatic box_t narrow(input wbox_t b);
    box_t o;
    o.x = b.x[12:0];
    o.y = b.y[12:0];
    o.w = b.w[13:0];
    o.h = b.h[13:0];
    return o;
  endfunction

  function automatic logic [13:0] eff_dim(input logic [13:0] v);
    return (v > 14'(FRAME_LIMIT)) ? 14'(FRAME_LIMIT) : v;
  endfunction

  function automatic clamp_t clamp_box(input wbox_t b, input logic [13:0] fw,
                                       input logic [13:0] fh);
    clamp_t o;
    logic signed [17:0] sfw;
    logic signed [17:0] sfh;
    sfw = signed'({4'd0, fw});
    sfh = signed'({4'd0, fh});
    o.b = b;
    o.ok = 1'b1;
    if (b.w <= 0 || b.h <= 0) begin
      o.ok = 1'b0;
    end
    if (o.b.x < 0) begin
      o.b.w = o.b.w + o.b.x;
      o.b.x = '0;
    end
    if (o.b.y < 0) begin
      o.b.h = o.b.h + o.b.y;
      o.b.y = '0;
    end
    if (o.b.x + o.b.w > sfw) begin
      o.b.w = sfw - o.b.x;
    end
    if (o.b.y + o.b.h > sfh) begin
      o.b.h = sfh - o.b.y;
    end
    if (o.b.w <= 0 || o.b.h <= 0) begin
      o.ok = 1'b0;
    end
    return o;
  endfunction

  function automatic logic is_full(input wbox_t b, input logic [13:0] fw,
                                   input logic [13:0] fh);
    return (b.x == 0) && (b.y == 0) && (b.w == signed'({4'd0, fw})) &&
           (b.h == signed'({4'd0, fh}));
  endfunction

  function automatic logic touches(input wbox_t a, input wbox_t b,
                                   input logic [3:0] pad);
    logic signed [17:0] p;
    logic t;
    p = signed'({14'd0, pad});
    t = 1'b1;
    if (a.x + a.w + p <= b.x || b.x + b.w <= a.x - p) begin
      t = 1'b0;
    end
    if (a.y + a.h + p <= b.y || b.y + b.h <= a.y - p) begin
      t = 1'b0;
    end
    return t;
  endfunction

  function automatic wbox_t unite(input wbox_t a, input wbox_t b);
    wbox_t o;
    logic signed [17:0] x2;
    logic signed [17:0] y2;
    o.x = (a.x < b.x) ? a.x : b.x;
    o.y = (a.y < b.y) ? a.y : b.y;
    x2 = (a.x + a.w > b.x + b.w) ? a.x + a.w : b.x + b.w;
    y2 = (a.y + a.h > b.y + b.h) ? a.y + a.h : b.y + b.h;
    o.w = x2 - o.x;
    o.h = y2 - o.y;
    return o;
  endfunction

endpackage

>>> rtl/drac_rect_mem.sv
// Rectangle store: one write port and one registered read port.
// Depends on drac_pkg for box_t.
module drac_rect_mem import drac_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  box_t                     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output box_t                     rd_data
);

  box_t mem [DEPTH];
  box_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/damage_rect_accumulator_core.sv
// Damage rectangle accumulator top level: sequencer, geometry functions and
// area accumulator. Depends on drac_pkg and drac_rect_mem.
//
//   Port group   Direction  Handshake            Payload
//   in_*         input      in_valid/in_ready    in_req_t
//   out_*        output     out_valid/out_ready  out_req_t
//   cfg_*        input      cfg_we               cfg_addr, cfg_wdata
//
// An add that is dropped, replaces the list or starts it is done in ST_IDLE. Otherwise a
// single entry first gets a full-frame check, each stored rectangle is read and checked in
// the scan, the absorb pass reads and checks each other entry and moves the last entry into
// the slot of each one absorbed, and a full list is collapsed into its bounding box.
// A capture reads, multiplies and accumulates each rectangle for the area pass, works out
// the threshold and flag, then reads, loads and offers each rectangle until it is accepted.
// Reset is synchronous and empties the list; the store itself is not cleared.
// A stalled result holds the block; no new request is taken until the last
// rectangle of a capture is accepted.
module damage_rect_accumulator_core import drac_pkg::*; #(
  parameter int unsigned MAX_RECTS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_req_t          out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int unsigned IW = $clog2(MAX_RECTS);
  localparam int unsigned CW = $clog2(MAX_RECTS + 1);

  logic [13:0] fw_cfg_r, fh_cfg_r;
  logic [3:0]  pad_r;
  logic [6:0]  smax_r, pct_r;

  state_t st_r, st_nxt;
  wbox_t  r_r, r_nxt, cur_r, cur_nxt, bb_r, bb_nxt;
  logic [IW-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [CW-1:0] j_r, j_nxt, cnt_r, cnt_nxt;
  logic [26:0] fa_r, fa_nxt;
  logic [27:0] prod_r, prod_nxt, dmg_r, dmg_nxt;
  logic [33:0] thr_r, thr_nxt;
  logic anyfull_r, anyfull_nxt, flag_r, flag_nxt;
  out_req_t out_r, out_nxt;

  logic          mem_we;
  logic [IW-1:0] wr_addr, rd_addr;
  box_t          wr_data, rd_data;

  logic [13:0] fw, fh;
  wbox_t  d_w, in_w, full_w;
  clamp_t in_cl, bb_cl;
  logic   scan_touch, abs_touch, i_is_last, k_last, j_end, j_is_i, in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_cfg_r <= 14'd1920;
      fh_cfg_r <= 14'd1080;
      pad_r    <= 4'd1;
      smax_r   <= 7'd32;
      pct_r    <= 7'd70;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  fw_cfg_r <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_cfg_r <= cfg_wdata;
        REG_MERGE_PAD:    pad_r    <= cfg_wdata[3:0];
        REG_SIGNAL_MAX:   smax_r   <= cfg_wdata[6:0];
        REG_AREA_PERCENT: pct_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  drac_rect_mem #(.DEPTH(MAX_RECTS)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign fw = eff_dim(fw_cfg_r);
  assign fh = eff_dim(fh_cfg_r);
  assign d_w = widen(rd_data);
  assign in_w.x = 18'(in_data.rect_x);
  assign in_w.y = 18'(in_data.rect_y);
  assign in_w.w = 18'(in_data.rect_w);
  assign in_w.h = 18'(in_data.rect_h);
  assign full_w.x = '0;
  assign full_w.y = '0;
  assign full_w.w = signed'({4'd0, fw});
  assign full_w.h = signed'({4'd0, fh});
  assign in_cl = clamp_box(in_w, fw, fh);
  assign bb_cl = clamp_box(bb_r, fw, fh);
  assign scan_touch = touches(d_w, r_r, pad_r);
  assign abs_touch = touches(cur_r, d_w, pad_r);
  assign i_is_last = (CW'(i_r) == cnt_r - CW'(1));
  assign k_last = (CW'(k_r) == cnt_r - CW'(1));
  assign j_end = (j_r >= cnt_r);
  assign j_is_i = (j_r == CW'(i_r));
  assign in_ready = (st_r == ST_IDLE);
  assign in_acc = in_valid && in_ready;
  assign out_valid = (st_r == ST_EM_WT);
  assign out_data = out_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.kind == KIND_ADD) begin
            if (!in_cl.ok || is_full(in_cl.b, fw, fh) || cnt_r == '0) begin
              st_nxt = ST_IDLE;
            end else if (cnt_r == CW'(1)) begin
              st_nxt = ST_ADD_F0;
            end else begin
              st_nxt = ST_SCAN_RD;
            end
          end else if (cnt_r == '0 && (fw == '0 || fh == '0)) begin
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_AR_RD;
          end
        end
      end
      ST_ADD_F0:   st_nxt = is_full(d_w, fw, fh) ? ST_IDLE : ST_SCAN_RD;
      ST_SCAN_RD:  st_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (scan_touch) begin
          st_nxt = ST_ABS_RD;
        end else if (!i_is_last) begin
          st_nxt = ST_SCAN_RD;
        end else if (cnt_r < CW'(MAX_RECTS)) begin
          st_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_COLLAPSE;
        end
      end
      ST_COLLAPSE: st_nxt = ST_IDLE;
      ST_ABS_RD: begin
        if (j_end) begin
          st_nxt = ST_IDLE;
        end else if (!j_is_i) begin
          st_nxt = ST_ABS_CHK;
        end
      end
      ST_ABS_CHK: st_nxt = abs_touch ? ST_ABS_MV : ST_ABS_RD;
      ST_ABS_MV:  st_nxt = ST_ABS_RD;
      ST_AR_RD:   st_nxt = ST_AR_MUL;
      ST_AR_MUL:  st_nxt = ST_AR_ACC;
      ST_AR_ACC:  st_nxt = k_last ? ST_AR_THR : ST_AR_RD;
      ST_AR_THR:  st_nxt = ST_AR_FLG;
      ST_AR_FLG:  st_nxt = ST_EM_RD;
      ST_EM_RD:   st_nxt = ST_EM_LD;
      ST_EM_LD:   st_nxt = ST_EM_WT;
      ST_EM_WT: begin
        if (out_ready) begin
          st_nxt = k_last ? ST_IDLE : ST_EM_RD;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    r_nxt = r_r;
    cur_nxt = cur_r;
    bb_nxt = bb_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    cnt_nxt = cnt_r;
    fa_nxt = fa_r;
    prod_nxt = prod_r;
    dmg_nxt = dmg_r;
    thr_nxt = thr_r;
    anyfull_nxt = anyfull_r;
    flag_nxt = flag_r;
    out_nxt = out_r;
    mem_we = 1'b0;
    wr_addr = '0;
    wr_data = narrow(in_cl.b);
    rd_addr = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          fa_nxt = 27'(fw * fh);
          if (in_data.kind == KIND_ADD) begin
            r_nxt = in_cl.b;
            bb_nxt = in_cl.b;
            i_nxt = '0;
            if (in_cl.ok && (is_full(in_cl.b, fw, fh) || cnt_r == '0)) begin
              mem_we = 1'b1;
              cnt_nxt = CW'(1);
            end
          end else begin
            k_nxt = '0;
            dmg_nxt = '0;
            anyfull_nxt = 1'b0;
            if (cnt_r == '0 && fw != '0 && fh != '0) begin
              mem_we = 1'b1;
              wr_data = narrow(full_w);
              cnt_nxt = CW'(1);
            end
          end
        end
      end
      ST_SCAN_RD: rd_addr = i_r;
      ST_SCAN_CHK: begin
        if (scan_touch) begin
          cur_nxt = unite(d_w, r_r);
          j_nxt = '0;
        end else begin
          bb_nxt = unite(bb_r, d_w);
          if (!i_is_last) begin
            i_nxt = i_r + IW'(1);
          end else if (cnt_r < CW'(MAX_RECTS)) begin
            mem_we = 1'b1;
            wr_addr = cnt_r[IW-1:0];
            wr_data = narrow(r_r);
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_COLLAPSE: begin
        wr_data = narrow(bb_cl.b);
        mem_we = bb_cl.ok;
        cnt_nxt = bb_cl.ok ? CW'(1) : '0;
      end
      ST_ABS_RD: begin
        if (j_end) begin
          mem_we = 1'b1;
          wr_addr = i_r;
          wr_data = narrow(cur_r);
        end else if (j_is_i) begin
          j_nxt = j_r + CW'(1);
        end else begin
          rd_addr = j_r[IW-1:0];
        end
      end
      ST_ABS_CHK: begin
        if (abs_touch) begin
          cur_nxt = unite(cur_r, d_w);
          rd_addr = IW'(cnt_r - CW'(1));
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_ABS_MV: begin
        mem_we = 1'b1;
        wr_addr = j_r[IW-1:0];
        wr_data = rd_data;
        if (i_is_last) begin
          i_nxt = j_r[IW-1:0];
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      ST_AR_RD: rd_addr = k_r;
      ST_AR_MUL: begin
        prod_nxt = rd_data.w * rd_data.h;
        anyfull_nxt = anyfull_r | is_full(d_w, fw, fh);
      end
      ST_AR_ACC: begin
        if (28'(fa_r) > dmg_r) begin
          dmg_nxt = dmg_r + prod_r;
        end
        if (!k_last) begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_AR_THR: thr_nxt = 34'(fa_r * pct_r);
      ST_AR_FLG: begin
        flag_nxt = !anyfull_r && (9'(cnt_r) <= 9'(smax_r)) && fa_r != '0 &&
                   (36'((36'(dmg_r) + 36'd1) * 36'(PERCENT_BASE)) <= 36'(thr_r));
        k_nxt = '0;
      end
      ST_EM_RD: rd_addr = k_r;
      ST_EM_LD: begin
        out_nxt.out_x = rd_data.x;
        out_nxt.out_y = rd_data.y;
        out_nxt.out_w = rd_data.w;
        out_nxt.out_h = rd_data.h;
        out_nxt.partial_damage = flag_r;
        out_nxt.last_rect = k_last;
        out_nxt.rect_total = 7'(cnt_r);
      end
      ST_EM_WT: begin
        if (out_ready) begin
          if (k_last) begin
            cnt_nxt = '0;
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
    end
    r_r <= r_nxt;
    cur_r <= cur_nxt;
    bb_r <= bb_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    fa_r <= fa_nxt;
    prod_r <= prod_nxt;
    dmg_r <= dmg_nxt;
    thr_r <= thr_nxt;
    anyfull_r <= anyfull_nxt;
    flag_r <= flag_nxt;
    out_r <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_RECTS))
    else $error("rectangle count above capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_rect |=> cnt_r == '0)
    else $error("list not cleared after the last rectangle");

endmodule

>>> bench/tb_damage_rect_accumulator_core.sv
// Testbench for damage_rect_accumulator_core: directed and random add and capture
// requests with random idling on both ports, checked against an in-bench predictor.
// Depends on drac_pkg and the RTL of the core.
`timescale 1ns / 1ps

module tb_damage_rect_accumulator_core;
  import drac_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_ready;
  out_req_t          out_data;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  damage_rect_accumulator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  in_req_t  pending_reqs[$];
  out_req_t expected_rects[$];

  int fw_r, fh_r, pad_r, smax_r, apct_r;
  int rx[64], ry[64], rw[64], rh[64];
  int rect_cnt;

  int errors = 0;
  int reqs_taken = 0;
  int rects_seen = 0;
  int captures_seen = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  bit no_gaps = 1'b0;
  int send_gap = 0;
  int recv_stall = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic int eff(int v);
    return (v > 8192) ? 8192 : v;
  endfunction

  function automatic bit clamp_rect(inout int x, inout int y, inout int w, inout int h);
    int fw, fh, cx, cy, cw, ch;
    fw = eff(fw_r);
    fh = eff(fh_r);
    cx = x; cy = y; cw = w; ch = h;
    if (cw <= 0 || ch <= 0) return 1'b0;
    if (cx < 0) begin
      cw += cx;
      cx = 0;
    end
    if (cy < 0) begin
      ch += cy;
      cy = 0;
    end
    if (cx + cw > fw) cw = fw - cx;
    if (cy + ch > fh) ch = fh - cy;
    if (cw <= 0 || ch <= 0) return 1'b0;
    x = cx; y = cy; w = cw; h = ch;
    return 1'b1;
  endfunction

  function automatic bit full_rect(int x, int y, int w, int h);
    return x == 0 && y == 0 && w == eff(fw_r) && h == eff(fh_r);
  endfunction

  function automatic bit rects_touch(int ax, int ay, int aw, int ah,
                                     int bx, int by, int bw, int bh);
    if (ax + aw + pad_r <= bx || bx + bw <= ax - pad_r) return 1'b0;
    if (ay + ah + pad_r <= by || by + bh <= ay - pad_r) return 1'b0;
    return 1'b1;
  endfunction

  task automatic grow_entry(int i, int x, int y, int w, int h);
    int x1, y1, x2, y2;
    x1 = (rx[i] < x) ? rx[i] : x;
    y1 = (ry[i] < y) ? ry[i] : y;
    x2 = (rx[i] + rw[i] > x + w) ? rx[i] + rw[i] : x + w;
    y2 = (ry[i] + rh[i] > y + h) ? ry[i] + rh[i] : y + h;
    rx[i] = x1; ry[i] = y1; rw[i] = x2 - x1; rh[i] = y2 - y1;
  endtask

  task automatic add_damage(int x0, int y0, int w0, int h0);
    int x, y, w, h, i, j, cx, cy, cw, ch;
    x = x0; y = y0; w = w0; h = h0;
    if (!clamp_rect(x, y, w, h)) return;
    if (full_rect(x, y, w, h)) begin
      rx[0] = x; ry[0] = y; rw[0] = w; rh[0] = h;
      rect_cnt = 1;
      return;
    end
    if (rect_cnt == 1 && full_rect(rx[0], ry[0], rw[0], rh[0])) return;
    i = 0;
    while (i < rect_cnt) begin
      if (rects_touch(rx[i], ry[i], rw[i], rh[i], x, y, w, h)) begin
        grow_entry(i, x, y, w, h);
        j = 0;
        while (j < rect_cnt) begin
          if (j != i && rects_touch(rx[i], ry[i], rw[i], rh[i], rx[j], ry[j], rw[j], rh[j]))
          begin
            grow_entry(i, rx[j], ry[j], rw[j], rh[j]);
            rx[j] = rx[rect_cnt-1]; ry[j] = ry[rect_cnt-1];
            rw[j] = rw[rect_cnt-1]; rh[j] = rh[rect_cnt-1];
            if (i == rect_cnt - 1) i = j;
            rect_cnt--;
          end else begin
            j++;
          end
        end
        return;
      end
      i++;
    end
    if (rect_cnt < 64) begin
      rx[rect_cnt] = x; ry[rect_cnt] = y; rw[rect_cnt] = w; rh[rect_cnt] = h;
      rect_cnt++;
      return;
    end
    for (i = 1; i < rect_cnt; i++) grow_entry(0, rx[i], ry[i], rw[i], rh[i]);
    grow_entry(0, x, y, w, h);
    cx = rx[0]; cy = ry[0]; cw = rw[0]; ch = rh[0];
    if (!clamp_rect(cx, cy, cw, ch)) begin
      rect_cnt = 0;
      return;
    end
    rx[0] = cx; ry[0] = cy; rw[0] = cw; rh[0] = ch;
    rect_cnt = 1;
  endtask

  function automatic bit partial_ok(int n);
    longint full_area, damage, threshold;
    int i;
    damage = 0;
    if (n == 0) return 1'b0;
    for (i = 0; i < n; i++)
      if (full_rect(rx[i], ry[i], rw[i], rh[i])) return 1'b0;
    if (n > smax_r) return 1'b0;
    full_area = longint'(eff(fw_r)) * longint'(eff(fh_r));
    if (full_area == 0) return 1'b0;
    for (i = 0; i < n; i++) begin
      if (rw[i] > 0 && rh[i] > 0) begin
        damage += longint'(rw[i]) * longint'(rh[i]);
        if (damage >= full_area) break;
      end
    end
    threshold = (full_area * longint'(apct_r)) / longint'(PERCENT_BASE);
    return damage < threshold;
  endfunction

  task automatic capture_damage();
    int n, k;
    bit part;
    out_req_t e;
    if (rect_cnt == 0) add_damage(0, 0, eff(fw_r), eff(fh_r));
    n = rect_cnt;
    part = partial_ok(n);
    for (k = 0; k < n; k++) begin
      e.out_x = 13'(rx[k]);
      e.out_y = 13'(ry[k]);
      e.out_w = 14'(rw[k]);
      e.out_h = 14'(rh[k]);
      e.partial_damage = part;
      e.last_rect = (k == n - 1);
      e.rect_total = 7'(n);
      expected_rects.push_back(e);
    end
    rect_cnt = 0;
  endtask

  task automatic report_diff(string field, int got, int want);
    $display("rect %0d: %s got %0d, expected %0d", rects_seen, field, got, want);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Requests are offered at the falling edge; valid stays up until taken.
  always @(negedge clk) begin
    logic    nv;
    in_req_t nd;
    nv = in_valid;
    nd = in_data;
    if (rst_n) begin
      if (in_valid && in_taken) begin
        nv = 1'b0;
        send_gap = pick_gap();
      end
      if (!nv) begin
        if (send_gap > 0) send_gap--;
        else if (pending_reqs.size() > 0) begin
          nd = pending_reqs.pop_front();
          nv = 1'b1;
        end
      end
    end
    in_valid <= nv;
    in_data <= nd;
  end

  // The receiver stalls at random, and once holds off long enough to back up the input.
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (!hold_done && rects_seen >= 3) begin
      hold_done = 1'b1;
      hold_left = 500;
      rdy = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      recv_stall = pick_gap();
    end
    out_ready <= rst_n ? rdy : 1'b0;
  end

  always @(posedge clk) begin
    out_req_t e;
    in_taken = in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rects.size() == 0) begin
          report_diff("unexpected rect, out_x", out_data.out_x, -1);
        end else begin
          e = expected_rects.pop_front();
          if (out_data.out_x !== e.out_x) report_diff("out_x", out_data.out_x, e.out_x);
          if (out_data.out_y !== e.out_y) report_diff("out_y", out_data.out_y, e.out_y);
          if (out_data.out_w !== e.out_w) report_diff("out_w", out_data.out_w, e.out_w);
          if (out_data.out_h !== e.out_h) report_diff("out_h", out_data.out_h, e.out_h);
          if (out_data.partial_damage !== e.partial_damage)
            report_diff("partial_damage", out_data.partial_damage, e.partial_damage);
          if (out_data.last_rect !== e.last_rect)
            report_diff("last_rect", out_data.last_rect, e.last_rect);
          if (out_data.rect_total !== e.rect_total)
            report_diff("rect_total", out_data.rect_total, e.rect_total);
        end
        rects_seen++;
      end
      if (in_taken) begin
        reqs_taken++;
        if (in_data.kind == KIND_CAPTURE) begin
          captures_seen++;
          capture_damage();
        end else begin
          add_damage(int'(in_data.rect_x), int'(in_data.rect_y),
                     int'(in_data.rect_w), int'(in_data.rect_h));
        end
      end
      if (in_taken || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("timeout after %0d requests", reqs_taken);
        $display("damage_rect_accumulator_core: mismatch");
        $finish;
      end
    end
  end

  task automatic push_req(logic kind, int x, int y, int w, int h);
    in_req_t r;
    r.kind = kind;
    r.rect_x = 16'(x);
    r.rect_y = 16'(y);
    r.rect_w = 16'(w);
    r.rect_h = 16'(h);
    pending_reqs.push_back(r);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_DW'(value);
    case (addr)
      REG_FRAME_WIDTH:  fw_r = value & 16'h3FFF;
      REG_FRAME_HEIGHT: fh_r = value & 16'h3FFF;
      REG_MERGE_PAD:    pad_r = value & 4'hF;
      REG_SIGNAL_MAX:   smax_r = value & 7'h7F;
      REG_AREA_PERCENT: apct_r = value & 7'h7F;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(int fw, int fh, int pad, int smax, int apct);
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_MERGE_PAD, pad);
    write_reg(REG_SIGNAL_MAX, smax);
    write_reg(REG_AREA_PERCENT, apct);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid || expected_rects.size() != 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Mostly rectangles around the frame, some captures and some raw noise.
  task automatic queue_random(int n, int span, bit end_capture);
    int k, r, sz;
    sz = (span / 3 > 4) ? span / 3 : 4;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 12)
        push_req(KIND_CAPTURE, $urandom, $urandom, $urandom, $urandom);
      else if (r < 20)
        push_req(KIND_ADD, $urandom, $urandom, $urandom, $urandom);
      else
        push_req(KIND_ADD, int'($urandom_range(0, span + 40)) - 20,
                 int'($urandom_range(0, span + 40)) - 20,
                 int'($urandom_range(0, sz)) - 3, int'($urandom_range(0, sz)) - 3);
    end
    if (end_capture) push_req(KIND_CAPTURE, 0, 0, 0, 0);
  endtask

  task automatic queue_grid(int n);
    int k;
    for (k = 0; k < n; k++) push_req(KIND_ADD, (k % 8) * 100, (k / 8) * 100, 10, 10);
    push_req(KIND_CAPTURE, 0, 0, 0, 0);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    fw_r = 1920; fh_r = 1080; pad_r = 1; smax_r = 32; apct_r = 70;
    rect_cnt = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_req(KIND_CAPTURE, 0, 0, 0, 0);
    push_req(KIND_ADD, -32768, -32768, 32767, 32767);
    push_req(KIND_ADD, 32767, 32767, 32767, 32767);
    push_req(KIND_ADD, 0, 0, -32768, 5);
    push_req(KIND_ADD, 0, 0, 0, 0);
    push_req(KIND_ADD, -10, -10, 30, 30);
    push_req(KIND_ADD, 21, 0, 5, 5);
    push_req(KIND_ADD, 100, 100, 10, 10);
    push_req(KIND_ADD, 19, 19, 5, 5);
    push_req(KIND_CAPTURE, -1, -1, -1, -1);
    push_req(KIND_ADD, 0, 0, 1920, 1080);
    push_req(KIND_ADD, 5, 5, 5, 5);
    push_req(KIND_CAPTURE, 0, 0, 0, 0);
    push_req(KIND_ADD, 0, 0, 4000, 4000);
    push_req(KIND_CAPTURE, 0, 0, 0, 0);
    // The growing entry is the last one and moves into the slot it frees.
    push_req(KIND_ADD, 0, 0, 10, 10);
    push_req(KIND_ADD, 500, 500, 10, 10);
    push_req(KIND_ADD, 20, 0, 10, 30);
    push_req(KIND_ADD, 5, 20, 20, 5);
    push_req(KIND_CAPTURE, 0, 0, 0, 0);
    drain();

    set_config(64, 48, 0, 64, 100);
    queue_random(15, 64, 1'b1);
    drain();

    no_gaps = 1'b1;
    set_config(8192, 8192, 0, 64, 100);
    queue_grid(66);
    drain();
    no_gaps = 1'b0;

    set_config(16383, 16383, 15, 0, 0);
    queue_random(12, 300, 1'b1);
    push_req(KIND_ADD, 3, 4, 50, 60);
    push_req(KIND_ADD, 200, 200, 9, 9);
    drain();

    set_config(0, 100, 3, 10, 50);
    queue_random(6, 100, 1'b1);
    push_req(KIND_CAPTURE, 0, 0, 0, 0);
    drain();

    set_config(200, 150, 15, 3, 127);
    queue_random(15, 200, 1'b1);
    drain();

    set_config(1920, 1080, 2, 32, 70);
    queue_random(12, 1900, 1'b1);
    drain();

    $display("%0d requests taken, %0d captures, %0d rectangles checked, %0d errors",
             reqs_taken, captures_seen, rects_seen, errors);
    $display("covered clamping, full-frame replace, merging, list collapse and flag rules");
    if (errors == 0) begin
      $display("damage_rect_accumulator_core: match");
    end else begin
      $display("damage_rect_accumulator_core: mismatch");
    end
    $finish;
  end

endmodule
